@@ rtl/log_softmax_row_core_macros.svh @@
// assertion macros for the log-softmax row core
`ifndef LOG_SOFTMAX_ROW_CORE_MACROS_SVH
`define LOG_SOFTMAX_ROW_CORE_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define LSR_CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define LSR_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lsr_pkg.sv @@
// constants, operation codes and exponent table function for the log-softmax row core
`timescale 1ns / 1ps

package lsr_pkg;

    // field and accumulator widths
    localparam int LOGIT_W = 16;
    localparam int SUM_W   = 32;

    // exponent table geometry: 2^(-k/EXP_TABLE_DEPTH) for k = 0..EXP_TABLE_DEPTH
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int TBL_IDX_W       = EXP_IDX_W + 1;
    localparam int Y_FRAC_W        = 24;
    localparam int REM_W           = Y_FRAC_W - EXP_IDX_W;
    localparam int TBL_W           = 17;
    localparam int EXP_SHIFT_MAX   = 16;

    // log2 fraction bits found by repeated squaring
    localparam int SQ_STEPS = 16;

    // fixed-point constants
    localparam logic [31:0]           ONE_Q16   = 32'd65536;
    localparam logic [31:0]           LOG2E_Q16 = 32'd94548;
    localparam logic [31:0]           LN2_Q16   = 32'd45426;
    localparam longint unsigned       LN2_Q30   = 64'd744261118;
    localparam logic signed [15:0]    LN_EPS_Q8 = -16'sd5895;
    localparam logic signed [15:0]    RUN_MAX_RESET = 16'sh8000;
    localparam logic signed [15:0]    LOGP_MIN  = 16'sh8000;
    localparam logic signed [15:0]    LOGP_MAX  = 16'sh7fff;

    // operation codes
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_NORM  = 1'b1;

    // 2^(-k/EXP_TABLE_DEPTH) in Q16, from the series for exp(-z) in Q30, rounded
    function automatic logic [TBL_W-1:0] pow2_neg_frac(input int unsigned k);
        longint unsigned z;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned q;
        begin
            z    = (64'(k) * LN2_Q30) / EXP_TABLE_DEPTH;
            term = 64'd1 << 30;
            pos  = 64'd1 << 30;
            neg  = 64'd0;
            for (int n = 1; n <= 16; n++)
            begin
                q = (term * z) >> 30;
                case (n)
                    1:       term = q;
                    2:       term = q / 2;
                    3:       term = q / 3;
                    4:       term = q / 4;
                    5:       term = q / 5;
                    6:       term = q / 6;
                    7:       term = q / 7;
                    8:       term = q / 8;
                    9:       term = q / 9;
                    10:      term = q / 10;
                    11:      term = q / 11;
                    12:      term = q / 12;
                    13:      term = q / 13;
                    14:      term = q / 14;
                    15:      term = q / 15;
                    16:      term = q / 16;
                    default: term = q;
                endcase
                if ((n % 2) == 1)
                begin
                    neg = neg + term;
                end
                else
                begin
                    pos = pos + term;
                end
            end
            pow2_neg_frac = TBL_W'(((pos - neg) + (64'd1 << 13)) >> 14);
        end
    endfunction

endpackage

@@ rtl/log_softmax_row_core.sv @@
// log-softmax over one row of Q7.8 logits with a shared multiplier and a small sequencer
`timescale 1ns / 1ps
`include "log_softmax_row_core_macros.svh"

// Log-softmax row core. The row is sent twice: first every logit with operation 0
// (accumulate), which keeps a running maximum and a running sum of exponentials,
// rescaling the sum whenever the maximum rises; the logit flagged row_end latches the
// row maximum and the natural log of the sum. Then every logit again with operation 1
// (normalize), each giving one transfer of log_prob = logit - max - ln(sum) in Q7.8,
// saturated, with final_res copying row_end. One item is taken at a time and in_stall
// stays high until it is done. All multiplications share one 32x32 multiplier: an accumulate
// item passes through scaling to the log2 domain, table interpolation, shift and sum update
// before the next transfer can be taken, and the accumulate item carrying row_end goes on to
// the logarithm (one leading-one shift per cycle, then 16 squaring steps and a final
// multiply by ln2). A normalize item waits in its state until the output register is free;
// its result waits in an output register, so the next item can be taken meanwhile.
module log_softmax_row_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic signed [lsr_pkg::LOGIT_W-1:0]   logit,
    input  logic                                 row_end,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [lsr_pkg::LOGIT_W-1:0]   log_prob,
    output logic                                 final_res
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NORM  = 4'd1;
    localparam logic [3:0] S_EXP1  = 4'd2;
    localparam logic [3:0] S_EXP2  = 4'd3;
    localparam logic [3:0] S_EXP3  = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_SQ    = 4'd7;
    localparam logic [3:0] S_LNMUL = 4'd8;

    localparam int LW = lsr_pkg::LOGIT_W;
    localparam int SW = lsr_pkg::SUM_W;
    localparam int TW = lsr_pkg::TBL_W;

    // control and architectural state
    logic [3:0]           state_reg, state_next;
    logic [3:0]           step_reg, step_next;
    logic [4:0]           p_reg, p_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [LW-1:0] running_max_reg, running_max_next;
    logic [SW-1:0]        exp_sum_reg, exp_sum_next;
    logic signed [LW-1:0] log_norm_reg, log_norm_next;
    logic signed [LW-1:0] row_max_reg, row_max_next;

    // datapath registers
    logic                 op_reg, op_next;
    logic signed [LW-1:0] logit_reg, logit_next;
    logic                 last_reg, last_next;
    logic                 up_reg, up_next;
    logic [LW-1:0]        diff_reg, diff_next;
    logic [32:0]          y_reg, y_next;
    logic [TW-1:0]        v_reg, v_next;
    logic [TW-1:0]        e_reg, e_next;
    logic [SW-1:0]        n_reg, n_next;
    logic [SW-2:0]        m_reg, m_next;
    logic [15:0]          frac_reg, frac_next;
    logic signed [LW-1:0] log_prob_reg, log_prob_next;
    logic                 final_res_reg, final_res_next;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // exponent table, constant per entry
    logic [TW-1:0] pow2_tbl [0:lsr_pkg::EXP_TABLE_DEPTH];

    for (genvar g = 0; g <= lsr_pkg::EXP_TABLE_DEPTH; g++)
    begin : g_tbl
        assign pow2_tbl[g] = lsr_pkg::pow2_neg_frac(g);
    end

    // table lookup at the fraction of the scaled exponent
    logic [lsr_pkg::EXP_IDX_W-1:0] tbl_idx;
    logic [lsr_pkg::TBL_IDX_W-1:0] tbl_idx_a, tbl_idx_b;
    logic [TW-1:0]                 tbl_a, tbl_b;

    assign tbl_idx   = y_reg[lsr_pkg::Y_FRAC_W-1 -: lsr_pkg::EXP_IDX_W];
    assign tbl_idx_a = {1'b0, tbl_idx};
    assign tbl_idx_b = tbl_idx_a + lsr_pkg::TBL_IDX_W'(1);
    assign tbl_a     = pow2_tbl[tbl_idx_a];
    assign tbl_b     = pow2_tbl[tbl_idx_b];

    // handshake outputs
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign log_prob  = log_prob_reg;
    assign final_res = final_res_reg;

    // multiplier operand select by step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_EXP1:
            begin
                mul_a = 32'(diff_reg);
                mul_b = lsr_pkg::LOG2E_Q16;
            end
            S_EXP2:
            begin
                mul_a = 32'(tbl_a - tbl_b);
                mul_b = 32'(y_reg[lsr_pkg::REM_W-1:0]);
            end
            S_UPD:
            begin
                mul_a = exp_sum_reg;
                mul_b = 32'(e_reg);
            end
            S_SQ:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            S_LNMUL:
            begin
                mul_a = 32'({p_reg[3:0], frac_reg});
                mul_b = lsr_pkg::LN2_Q16;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // sequencer and datapath next state
    logic [33:0]          sum_wide;
    logic [SW-1:0]        sum_sat;
    logic [31:0]          sq;
    logic [35:0]          ln_round;
    logic signed [17:0]   norm_diff;

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        p_next           = p_reg;
        out_valid_next   = out_valid_reg;
        running_max_next = running_max_reg;
        exp_sum_next     = exp_sum_reg;
        log_norm_next    = log_norm_reg;
        row_max_next     = row_max_reg;
        op_next          = op_reg;
        logit_next       = logit_reg;
        last_next        = last_reg;
        up_next          = up_reg;
        diff_next        = diff_reg;
        y_next           = y_reg;
        v_next           = v_reg;
        e_next           = e_reg;
        n_next           = n_reg;
        m_next           = m_reg;
        frac_next        = frac_reg;
        log_prob_next    = log_prob_reg;
        final_res_next   = final_res_reg;

        sum_wide  = '0;
        sum_sat   = '0;
        sq        = mul_p[61:30];
        ln_round  = mul_p[35:0] + 36'd8388608;
        norm_diff = 18'(logit_reg) - 18'(row_max_reg) - 18'(log_norm_reg);

        // output register empties on a transfer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // take an item
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    logit_next = logit;
                    last_next  = row_end;
                    up_next    = (logit > running_max_reg);
                    if (logit > running_max_reg)
                    begin
                        diff_next = LW'(logit - running_max_reg);
                    end
                    else
                    begin
                        diff_next = LW'(running_max_reg - logit);
                    end
                    if (operation == lsr_pkg::OP_NORM)
                    begin
                        state_next = S_NORM;
                    end
                    else
                    begin
                        state_next = S_EXP1;
                    end
                end
            end

            // normalize and load the output register once it is free
            S_NORM:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (norm_diff < 18'(lsr_pkg::LOGP_MIN))
                    begin
                        log_prob_next = lsr_pkg::LOGP_MIN;
                    end
                    else if (norm_diff > 18'(lsr_pkg::LOGP_MAX))
                    begin
                        log_prob_next = lsr_pkg::LOGP_MAX;
                    end
                    else
                    begin
                        log_prob_next = norm_diff[LW-1:0];
                    end
                    final_res_next = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // difference scaled by log2(e), Q24
            S_EXP1:
            begin
                y_next     = mul_p[32:0];
                state_next = S_EXP2;
            end

            // linear interpolation between table entries
            S_EXP2:
            begin
                v_next     = tbl_a - mul_p[lsr_pkg::REM_W + TW - 1:lsr_pkg::REM_W];
                state_next = S_EXP3;
            end

            // integer part of the exponent as a right shift
            S_EXP3:
            begin
                if (y_reg[32:24] > 9'(lsr_pkg::EXP_SHIFT_MAX))
                begin
                    e_next = '0;
                end
                else
                begin
                    e_next = v_reg >> y_reg[28:24];
                end
                state_next = S_UPD;
            end

            // rescale or add, saturate, and close the row on its last logit
            S_UPD:
            begin
                if (up_reg)
                begin
                    sum_wide = {1'b0, mul_p[48:16]} + 34'(lsr_pkg::ONE_Q16);
                end
                else
                begin
                    sum_wide = 34'(exp_sum_reg) + 34'(e_reg);
                end
                sum_sat = (sum_wide[33:32] != 2'b00) ? '1 : sum_wide[SW-1:0];
                if (last_reg)
                begin
                    row_max_next     = up_reg ? logit_reg : running_max_reg;
                    running_max_next = lsr_pkg::RUN_MAX_RESET;
                    exp_sum_next     = '0;
                    n_next           = sum_sat;
                    p_next           = 5'(SW - 1);
                    if (sum_sat == '0)
                    begin
                        log_norm_next = lsr_pkg::LN_EPS_Q8;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    exp_sum_next = sum_sat;
                    if (up_reg)
                    begin
                        running_max_next = logit_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            // leading-one search, one bit a cycle
            S_SHIFT:
            begin
                if (n_reg[SW-1])
                begin
                    m_next     = n_reg[SW-1:1];
                    frac_next  = '0;
                    step_next  = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    n_next = n_reg << 1;
                    p_next = p_reg - 5'd1;
                end
            end

            // one log2 fraction bit per squaring
            S_SQ:
            begin
                if (sq[31])
                begin
                    m_next    = sq[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next    = sq[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(lsr_pkg::SQ_STEPS - 1))
                begin
                    state_next = S_LNMUL;
                end
            end

            // log2 times ln2, rounded to Q7.8; sums below one clamp to zero
            S_LNMUL:
            begin
                if (p_reg[4])
                begin
                    log_norm_next = LW'(ln_round[35:24]);
                end
                else
                begin
                    log_norm_next = '0;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            p_reg           <= '0;
            out_valid_reg   <= 1'b0;
            running_max_reg <= lsr_pkg::RUN_MAX_RESET;
            exp_sum_reg     <= '0;
            log_norm_reg    <= '0;
            row_max_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            p_reg           <= p_next;
            out_valid_reg   <= out_valid_next;
            running_max_reg <= running_max_next;
            exp_sum_reg     <= exp_sum_next;
            log_norm_reg    <= log_norm_next;
            row_max_reg     <= row_max_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        logit_reg     <= logit_next;
        last_reg      <= last_next;
        up_reg        <= up_next;
        diff_reg      <= diff_next;
        y_reg         <= y_next;
        v_reg         <= v_next;
        e_reg         <= e_next;
        n_reg         <= n_next;
        m_reg         <= m_next;
        frac_reg      <= frac_next;
        log_prob_reg  <= log_prob_next;
        final_res_reg <= final_res_next;
    end

    // accumulate transfer always starts the exponent sequence
    `LSR_CHECK_NEXT(a_accum_start, (state_reg == S_IDLE) && in_valid && (operation == lsr_pkg::OP_ACCUM), (state_reg == S_EXP1) && (op_reg == lsr_pkg::OP_ACCUM), "accumulate item did not start exponent sequence")

    // running values are back at reset while the log is formed, and the search has a one to find
    `LSR_CHECK_SAME(a_row_closed, (state_reg == S_SHIFT), (exp_sum_reg == '0) && (running_max_reg == lsr_pkg::RUN_MAX_RESET) && (n_reg != '0), "row not closed before logarithm")

    // mantissa stays normalised in [1, 2) through the squaring steps
    `LSR_CHECK_SAME(a_mant_norm, (state_reg == S_SQ), m_reg[SW-2], "log2 mantissa lost normalisation")

    // a result appears only from the normalize step
    `LSR_CHECK_SAME(a_out_source, $rose(out_valid_reg), $past(state_reg) == S_NORM, "result loaded outside normalize step")

endmodule
